// File: sv/dlq_pkg.sv
`default_nettype none

package dlq_pkg;

  localparam int DATA_W    = 32;
  localparam int DEF_DEPTH = 16;

  // opcodes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_POP_FRONT  = 3'd1;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SEARCH     = 3'd4;
  localparam logic [2:0] OP_DUMP       = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } dlq_state_t;

endpackage

`default_nettype wire

// File: sv/dlq_ram.sv
`default_nettype none

module dlq_ram #(
  parameter int DEPTH = dlq_pkg::DEF_DEPTH,
  parameter int AW    = $clog2(dlq_pkg::DEF_DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [dlq_pkg::DATA_W-1:0] wr_data,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             rd_addr,
  output logic      [dlq_pkg::DATA_W-1:0] rd_data
);
  import dlq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/deque_with_linear_search.sv
`default_nettype none

// Bounded double-ended queue of signed 32-bit words held in a DEPTH-entry
// single-port-read ring memory. Push and pop at either end answer directly:
// the word is accepted and its single result word is offered on the next
// cycle. Search and dump walk the stored words front to back through the
// memory's one read port through a registered read, one word per cycle while
// rsp_stall is low: a search stops at the first match,
// a dump of n words gives n result words at one per cycle while rsp_stall is
// low, the last marked by last_item. A push on a full queue is dropped with
// status full, a pop or dump on an empty queue reports status empty. A new
// word is taken only once the previous one has finished its walk, and no
// earlier than the cycle in which its last result word leaves; a result held
// by rsp_stall holds off the next word. Storage needs no clearing after
// reset; the queue starts empty.
module deque_with_linear_search #(
  parameter int DEPTH = dlq_pkg::DEF_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_stall,
  input  wire logic [2:0]                       opcode,
  input  wire logic signed [dlq_pkg::DATA_W-1:0] item_in,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_stall,
  output logic      [1:0]                       status,
  output logic                                  found,
  output logic signed [dlq_pkg::DATA_W-1:0]     item_out,
  output logic                                  last_item,
  output logic      [$clog2(DEPTH+1)-1:0]       occupancy
);
  import dlq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_S   = (AW+1)'(DEPTH);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    wrap_inc = (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  dlq_state_t state;
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic          is_dump;
  logic [DATA_W-1:0] key;
  logic [CW-1:0] iss, cons;
  logic [AW-1:0] rd_addr;
  logic          dv;
  logic [DATA_W-1:0] rd_data;

  logic out_free, accept, consume, issue, match, last_elem, done_now;
  logic start_scan, wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    imm_status;
  logic [AW:0]   bsum, bsub;
  logic [AW-1:0] back_addr, front_dec;
  logic full, empty;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !(state == S_IDLE && out_free);
  assign accept    = req_valid && !req_stall;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);

  assign bsum      = (AW+1)'(front) + (AW+1)'(count);
  assign bsub      = bsum - DEPTH_S;
  assign back_addr = (bsum >= DEPTH_S) ? bsub[AW-1:0] : bsum[AW-1:0];
  assign front_dec = (front == '0) ? LAST_ADDR : front - 1'b1;

  // decode of an accepted word
  always_comb begin
    front_next = front;
    count_next = count;
    imm_status = ST_OK;
    wr_en      = 1'b0;
    wr_addr    = back_addr;
    start_scan = 1'b0;
    unique case (opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          imm_status = ST_FULL;
        end else begin
          front_next = front_dec;
          wr_addr    = front_dec;
          wr_en      = accept;
          count_next = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          imm_status = ST_EMPTY;
        end else begin
          front_next = wrap_inc(front);
          count_next = count - 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          imm_status = ST_FULL;
        end else begin
          wr_en      = accept;
          count_next = count + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          imm_status = ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      OP_SEARCH: begin
        start_scan = !empty;
      end
      OP_DUMP: begin
        if (empty) begin
          imm_status = ST_EMPTY;
        end else begin
          start_scan = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // scan side: rd_data is the word at offset cons when dv is set
  assign match     = (rd_data == key);
  assign last_elem = (cons + 1'b1 == count);
  assign consume   = dv && out_free;
  assign done_now  = consume && (last_elem || (match && !is_dump));
  assign issue     = (state == S_SCAN) && (iss < count) && (!dv || consume) && !done_now;

  dlq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (item_in),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      dv    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            front <= front_next;
            count <= count_next;
            if (start_scan) begin
              state <= S_SCAN;
            end
          end
          dv <= 1'b0;
        end
        S_SCAN: begin
          if (done_now) begin
            state <= S_IDLE;
            dv    <= 1'b0;
          end else if (issue) begin
            dv <= 1'b1;
          end else if (consume) begin
            dv <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && start_scan) begin
      iss     <= '0;
      cons    <= '0;
      rd_addr <= front;
      key     <= item_in;
      is_dump <= (opcode == OP_DUMP);
    end else begin
      if (issue) begin
        iss     <= iss + 1'b1;
        rd_addr <= wrap_inc(rd_addr);
      end
      if (consume) begin
        cons <= cons + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= !start_scan;
    end else if (consume && (is_dump || done_now)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !start_scan) begin
      status    <= imm_status;
      found     <= 1'b0;
      item_out  <= '0;
      last_item <= 1'b1;
      occupancy <= count_next;
    end else if (consume && is_dump) begin
      status    <= ST_OK;
      found     <= 1'b0;
      item_out  <= rd_data;
      last_item <= last_elem;
      occupancy <= count;
    end else if (done_now) begin
      status    <= ST_OK;
      found     <= match;
      item_out  <= '0;
      last_item <= 1'b1;
      occupancy <= count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("element count above depth");

  a_scan_holds_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (count == $past(count)) && (front == $past(front)))
    else $error("queue changed during a walk");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_IDLE))
    else $error("memory write outside idle");

  a_dv_in_scan: assert property (@(posedge clk) disable iff (rst)
    dv |-> (state == S_SCAN) && (cons < iss))
    else $error("read data valid outside a walk");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (iss <= count))
    else $error("read issued past the back");

endmodule

`default_nettype wire

// File: verif/deque_checker.sv
module deque_checker #(
  parameter int DEPTH = dlq_pkg::DEF_DEPTH,
  parameter int OCC_W = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  input  logic                             req_stall,
  input  logic [2:0]                       opcode,
  input  logic signed [dlq_pkg::DATA_W-1:0] item_in,
  input  logic                             rsp_valid,
  input  logic                             rsp_stall,
  input  logic [1:0]                       status,
  input  logic                             found,
  input  logic signed [dlq_pkg::DATA_W-1:0] item_out,
  input  logic                             last_item,
  input  logic [OCC_W-1:0]                 occupancy,
  output int                               fail_count,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dlq_pkg::*;

  typedef struct packed {
    logic [1:0]               status;
    logic                     found;
    logic signed [DATA_W-1:0] item;
    logic                     last;
    logic [OCC_W-1:0]         occ;
  } rsp_word_t;

  rsp_word_t         expected_words[$];
  logic [DATA_W-1:0] ring_mem[DEPTH];
  int                head_pos;
  int                held;
  rsp_word_t         got_word;
  rsp_word_t         want_word;

  function automatic int ring_slot(int offset);
    return (head_pos + offset) % DEPTH;
  endfunction

  // runs one request word on the shadow deque and queues the words it causes
  task automatic apply_deque_op(input logic [2:0] op, input logic [DATA_W-1:0] val);
    logic [1:0] st;
    logic       hit;
    logic       dumped;
    int         i;
    rsp_word_t  w;
    st = ST_OK;
    hit = 1'b0;
    dumped = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (held >= DEPTH) st = ST_FULL;
        else begin
          head_pos = (head_pos == 0) ? DEPTH - 1 : head_pos - 1;
          ring_mem[head_pos] = val;
          held++;
        end
      end
      OP_POP_FRONT: begin
        if (held == 0) st = ST_EMPTY;
        else begin
          head_pos = ring_slot(1);
          held--;
        end
      end
      OP_PUSH_BACK: begin
        if (held >= DEPTH) st = ST_FULL;
        else begin
          ring_mem[ring_slot(held)] = val;
          held++;
        end
      end
      OP_POP_BACK: begin
        if (held == 0) st = ST_EMPTY;
        else held--;
      end
      OP_SEARCH: begin
        for (i = 0; i < held; i++)
          if (ring_mem[ring_slot(i)] == val) hit = 1'b1;
      end
      OP_DUMP: begin
        if (held == 0) st = ST_EMPTY;
        else begin
          for (i = 0; i < held; i++) begin
            w.status = ST_OK;
            w.found = 1'b0;
            w.item = ring_mem[ring_slot(i)];
            w.last = (i == held - 1);
            w.occ = held[OCC_W-1:0];
            expected_words.push_back(w);
          end
          dumped = 1'b1;
        end
      end
      default: ;
    endcase
    if (!dumped) begin
      w.status = st;
      w.found = hit;
      w.item = '0;
      w.last = 1'b1;
      w.occ = held[OCC_W-1:0];
      expected_words.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_pos = 0;
      held = 0;
      fail_count = 0;
      expected_words.delete();
    end else begin
      // result first: a word taken at this edge cannot answer in the same edge
      if (rsp_valid && !rsp_stall) begin
        got_word = '{status, found, item_out, last_item, occupancy};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word: status=%0d found=%0d item_out=%0d last_item=%0d occupancy=%0d",
                   $time, status, found, item_out, last_item, occupancy);
          fail_count++;
        end else begin
          want_word = expected_words.pop_front();
          if (got_word !== want_word) begin
            $display("%0t: mismatch expected status=%0d found=%0d item_out=%0d last_item=%0d occupancy=%0d",
                     $time, want_word.status, want_word.found, want_word.item,
                     want_word.last, want_word.occ);
            $display("%0t:          actual status=%0d found=%0d item_out=%0d last_item=%0d occupancy=%0d",
                     $time, got_word.status, got_word.found, got_word.item,
                     got_word.last, got_word.occ);
            fail_count++;
          end
        end
      end
      if (req_valid && !req_stall) apply_deque_op(opcode, item_in);
    end
    pending = expected_words.size();
  end

endmodule

// File: verif/tb_deque_with_linear_search.sv
module tb_deque_with_linear_search;
  timeunit 1ns;
  timeprecision 1ps;
  import dlq_pkg::*;

  localparam int DEPTH = DEF_DEPTH;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [2:0]               opcode = OP_PUSH_FRONT;
  logic signed [DATA_W-1:0] item_in = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic [1:0]               status;
  logic                     found;
  logic signed [DATA_W-1:0] item_out;
  logic                     last_item;
  logic [OCC_W-1:0]         occupancy;
  int                       fail_count;
  int                       pending;

  int                snd_idle_pct = 0;
  int                rcv_stall_pct = 0;
  logic [DATA_W-1:0] pushed_vals[16];
  int                pushed_wr = 0;

  deque_with_linear_search DUT (.*);

  deque_checker #(.DEPTH(DEPTH)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) rsp_stall <= ($urandom_range(99) < rcv_stall_pct);

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_word(input logic [2:0] op, input logic [DATA_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    opcode <= op;
    item_in <= val;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
      pushed_vals[pushed_wr] = val;
      pushed_wr = (pushed_wr + 1) % 16;
    end
    do @(posedge clk); while (req_stall);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly pushes and pops so the deque swings between empty and full
  task automatic send_random_word(input int push_pct);
    int                sel;
    logic [DATA_W-1:0] v;
    sel = $urandom_range(99);
    if (sel < 4) send_word(OP_DUMP, $urandom);
    else if (sel < 12) begin
      v = $urandom_range(1) ? pushed_vals[$urandom_range(15)] : pick_value();
      send_word(OP_SEARCH, v);
    end else if (sel < 14) send_word(3'($urandom_range(7, 6)), $urandom);
    else if ($urandom_range(99) < push_pct)
      send_word($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
    else
      send_word($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
  endtask

  initial begin
    int ph;
    int k;
    for (k = 0; k < 16; k++) pushed_vals[k] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // empty deque corners
    send_word(OP_DUMP, '0);
    send_word(OP_POP_FRONT, '1);
    send_word(OP_POP_BACK, VAL_MIN);
    send_word(OP_SEARCH, '0);
    send_word(3'd6, VAL_MAX);
    send_word(3'd7, '1);
    // single word pops, then searches and dumps on a four-word deque
    send_word(OP_PUSH_BACK, VAL_MAX);
    send_word(OP_POP_BACK, '0);
    send_word(OP_PUSH_FRONT, VAL_MIN);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_PUSH_FRONT, '1);
    send_word(OP_PUSH_BACK, '0);
    send_word(OP_PUSH_FRONT, VAL_MIN);
    send_word(OP_PUSH_BACK, VAL_MAX);
    send_word(OP_SEARCH, VAL_MAX);
    send_word(OP_SEARCH, 32'h1234_5678);
    send_word(OP_SEARCH, VAL_MIN);
    send_word(OP_DUMP, '1);
    send_word(OP_POP_BACK, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_DUMP, '0);
    send_word(OP_SEARCH, '1);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 59; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 59; end
        default: begin snd_idle_pct = 31; rcv_stall_pct = 31; end
      endcase
      for (k = 0; k < 125; k++) send_random_word(((k / 30) % 2) ? 20 : 80);
    end

    @(negedge clk) req_valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
